/* hdl/block_table_first_fit_allocator_core_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define BTFFA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("btffa: same-cycle check failed");

// Next-cycle implication, checked while reset is released.
`define BTFFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("btffa: next-cycle check failed");

`endif

/* hdl/btffa_pkg.sv */
// Package with the constants and codes of the block table allocator.
package btffa_pkg;

    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam int ADDR_W = 32;
    // Run length in bytes can reach 2^32, one bit past the size field.
    localparam int RUN_W  = ADDR_W + 1;
    localparam int FLAG_W = 3;
    localparam int STATUS_W = 2;

    localparam int FLAG_TAKEN_BIT = 0;
    localparam int FLAG_FIRST_BIT = 1;
    localparam int FLAG_NEXT_BIT  = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    typedef logic [FLAG_W-1:0] flags_t;

endpackage

/* hdl/block_table_first_fit_allocator_core.sv */
// Block table first-fit allocator: request handling, table memory and sequencer.
// After reset the block table is swept clear one entry per cycle, so the core takes
// no request until the sweep is done. An allocate request then scans the table one
// entry per cycle through a single read port, up to the end of the first free run that
// is large enough, then marks each block of the granted run in the chain and hands off
// the result once the output register is free. A free request first steps through the
// heap one block per cycle to find its block index, then reads the entry and clears
// each block of the chain in turn. One request is in flight at a time; a finished
// response sits in the output register while the next request is taken.
`include "block_table_first_fit_allocator_core_defines.svh"

module block_table_first_fit_allocator_core #(
    parameter int NUM_BLOCKS  = btffa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = btffa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btffa_pkg::ADDR_W-1:0]        cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [btffa_pkg::ADDR_W-1:0]        s_size_bytes,
    input  logic [btffa_pkg::ADDR_W-1:0]        s_free_address,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [btffa_pkg::STATUS_W-1:0]      m_status,
    output logic [btffa_pkg::ADDR_W-1:0]        m_alloc_address
);

    localparam int IDX_W    = $clog2(NUM_BLOCKS);
    localparam int ADDR_W   = btffa_pkg::ADDR_W;
    localparam int RUN_W    = btffa_pkg::RUN_W;
    localparam int STATUS_W = btffa_pkg::STATUS_W;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [ADDR_W-1:0] BLK_ADDR  = ADDR_W'(BLOCK_BYTES);
    localparam logic [RUN_W-1:0]  BLK_RUN   = RUN_W'(BLOCK_BYTES);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_CLEAR   = 3'd0;
    localparam logic [ST_W-1:0] S_IDLE    = 3'd1;
    localparam logic [ST_W-1:0] S_SCAN    = 3'd2;
    localparam logic [ST_W-1:0] S_MARK    = 3'd3;
    localparam logic [ST_W-1:0] S_LOCATE  = 3'd4;
    localparam logic [ST_W-1:0] S_WALK_RD = 3'd5;
    localparam logic [ST_W-1:0] S_WALK    = 3'd6;
    localparam logic [ST_W-1:0] S_DONE    = 3'd7;

    logic [ST_W-1:0]     state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    start_idx_reg, start_idx_next;
    logic [IDX_W-1:0]    end_idx_reg, end_idx_next;
    logic [RUN_W-1:0]    run_bytes_reg, run_bytes_next;
    logic [ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic [ADDR_W-1:0]   start_addr_reg, start_addr_next;
    logic [ADDR_W-1:0]   off_reg, off_next;
    logic [ADDR_W-1:0]   size_reg, size_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0]   heap_base_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ADDR_W-1:0]   m_addr_reg, m_addr_next;

    // Block table: one write port, one registered read port.
    btffa_pkg::flags_t   flag_mem [NUM_BLOCKS];
    btffa_pkg::flags_t   rd_data_reg;
    btffa_pkg::flags_t   wr_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                mem_we;

    logic                idx_last;
    logic [IDX_W-1:0]    idx_inc;
    logic [RUN_W-1:0]    run_sum;
    logic [RUN_W-1:0]    free_diff;

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_alloc_address = m_addr_reg;

    assign idx_last  = (idx_reg == LAST_IDX);
    assign idx_inc   = idx_reg + 1'b1;
    assign run_sum   = run_bytes_reg + BLK_RUN;
    assign free_diff = {1'b0, s_free_address} - {1'b0, heap_base_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            flag_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= flag_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        start_idx_next  = start_idx_reg;
        end_idx_next    = end_idx_reg;
        run_bytes_next  = run_bytes_reg;
        cur_addr_next   = cur_addr_reg;
        start_addr_next = start_addr_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        rd_addr         = idx_reg;
        wr_addr         = idx_reg;
        wr_data         = '0;
        mem_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (idx_last) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_IDLE: begin
                // Entry zero is read here so the scan has data in its first cycle.
                rd_addr = '0;
                if (s_valid) begin
                    idx_next      = '0;
                    res_addr_next = '0;
                    if (s_cmd == btffa_pkg::CMD_ALLOC) begin
                        size_next      = s_size_bytes;
                        run_bytes_next = '0;
                        cur_addr_next  = heap_base_reg;
                        if (s_size_bytes == '0) begin
                            res_status_next = btffa_pkg::ST_BAD;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        off_next = free_diff[ADDR_W-1:0];
                        if (free_diff[ADDR_W]) begin
                            res_status_next = btffa_pkg::ST_BAD;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_LOCATE;
                        end
                    end
                end
            end
            S_SCAN: begin
                rd_addr = idx_last ? idx_reg : idx_inc;
                if (rd_data_reg[btffa_pkg::FLAG_TAKEN_BIT]) begin
                    run_bytes_next = '0;
                end else begin
                    run_bytes_next = run_sum;
                    if (run_bytes_reg == '0) begin
                        start_idx_next  = idx_reg;
                        start_addr_next = cur_addr_reg;
                    end
                end
                if (!rd_data_reg[btffa_pkg::FLAG_TAKEN_BIT] && (run_sum >= {1'b0, size_reg})) begin
                    end_idx_next  = idx_reg;
                    state_next    = S_MARK;
                    if (run_bytes_reg == '0) begin
                        idx_next      = idx_reg;
                        res_addr_next = cur_addr_reg;
                    end else begin
                        idx_next      = start_idx_reg;
                        res_addr_next = start_addr_reg;
                    end
                end else if (idx_last) begin
                    res_status_next = btffa_pkg::ST_NOMEM;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    idx_next      = idx_inc;
                    cur_addr_next = cur_addr_reg + BLK_ADDR;
                end
            end
            S_MARK: begin
                mem_we = 1'b1;
                wr_data[btffa_pkg::FLAG_TAKEN_BIT] = 1'b1;
                wr_data[btffa_pkg::FLAG_FIRST_BIT] = (idx_reg == start_idx_reg);
                wr_data[btffa_pkg::FLAG_NEXT_BIT]  = (idx_reg != end_idx_reg);
                if (idx_reg == end_idx_reg) begin
                    res_status_next = btffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_LOCATE: begin
                // Repeated subtraction turns the heap offset into a block index.
                if (off_reg < BLK_ADDR) begin
                    state_next = S_WALK_RD;
                end else if (idx_last) begin
                    res_status_next = btffa_pkg::ST_BAD;
                    state_next      = S_DONE;
                end else begin
                    off_next = off_reg - BLK_ADDR;
                    idx_next = idx_inc;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK;
            end
            S_WALK: begin
                rd_addr = idx_last ? idx_reg : idx_inc;
                mem_we  = 1'b1;
                if (!rd_data_reg[btffa_pkg::FLAG_NEXT_BIT] || idx_last) begin
                    res_status_next = btffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            heap_base_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                heap_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_idx_reg  <= start_idx_next;
        end_idx_reg    <= end_idx_next;
        run_bytes_reg  <= run_bytes_next;
        cur_addr_reg   <= cur_addr_next;
        start_addr_reg <= start_addr_next;
        off_reg        <= off_next;
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    `BTFFA_ASSERT_SAME(a_fail_addr_zero, aclk, aresetn, m_valid && (m_status != btffa_pkg::ST_OK), m_alloc_address == '0)
    `BTFFA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BTFFA_ASSERT_SAME(a_mark_in_run, aclk, aresetn, state_reg == S_MARK, (idx_reg >= start_idx_reg) && (idx_reg <= end_idx_reg))
    `BTFFA_ASSERT_SAME(a_no_result_in_clear, aclk, aresetn, state_reg == S_CLEAR, !m_valid_reg)

endmodule
